FILE: rtl/gauss_jordan_solver_macros.svh
// ----------------------------------------------------------------------------
// gauss_jordan_solver_macros
// Assertion helpers used by the solver top level.
// ----------------------------------------------------------------------------
`ifndef GAUSS_JORDAN_SOLVER_MACROS_SVH
`define GAUSS_JORDAN_SOLVER_MACROS_SVH

// same-cycle implication
`define GJS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define GJS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/gjs_pkg.sv
// ----------------------------------------------------------------------------
// gjs_pkg
// Types and constants of the Gauss-Jordan solver.
// ----------------------------------------------------------------------------
`default_nettype none

package gjs_pkg;

    localparam int MAX_ORDER = 16;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W     = 4;                  // row / column index of the stores
    localparam int N_W       = 5;                  // order and augmented column index
    localparam int DATA_W    = 32;
    localparam int NUM_W     = 2 * FRAC_BITS + 2;  // reciprocal dividend width

    typedef enum logic [1:0] {
        ACT_WR_MATRIX = 2'd0,
        ACT_WR_RHS    = 2'd1,
        ACT_SOLVE     = 2'd2,
        ACT_NONE      = 2'd3
    } gjs_action_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_PIVOT = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_RSVD       = 2'd3
    } gjs_status_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [DATA_W-1:0] entry_value;
    } gjs_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]        solution_index;
        logic signed [DATA_W-1:0] solution_value;
        logic                    last;
        logic [1:0]              status;
    } gjs_result_t;

    typedef struct packed {
        logic [IDX_W-1:0] a_row;
        logic [N_W-1:0]   a_col;
        logic [IDX_W-1:0] b_row;
        logic             clr_ovf;
        logic             cp_wr;
        logic             cp_rhs;
        logic             div_start;
        logic             ld_coef;
        logic             mul_en;
        logic             mul_scale;
        logic             rnd_en;
        logic             wr_en;
        logic             wr_sub;
        logic             emit;
        logic             emit_err;
        logic             last;
    } gjs_cmd_t;

    typedef struct packed {
        logic piv_zero;
        logic div_done;
    } gjs_sts_t;

endpackage

`default_nettype wire

FILE: rtl/gjs_recip.sv
// ----------------------------------------------------------------------------
// gjs_recip
// Restoring divider: rounded, saturated fixed-point reciprocal of the pivot.
// ----------------------------------------------------------------------------
`default_nettype none

module gjs_recip (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [gjs_pkg::DATA_W-1:0] pivot,
    output logic                               done,
    output logic signed [gjs_pkg::DATA_W-1:0]  recip,
    output logic                               ovf
);
    import gjs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] ONE_NUM = NUM_W'(1) << (2 * FRAC_BITS);
    localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(33'h0_7FFF_FFFF);
    localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(33'h0_8000_0000);

    logic                 run_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DATA_W-1:0]    div_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DATA_W:0]      rem_reg;
    logic                 neg_reg;
    logic                 done_reg;

    logic [DATA_W-1:0]    mag;
    logic [DATA_W:0]      rem_sh;
    logic                 fits;

    assign mag    = pivot[DATA_W-1] ? DATA_W'(-pivot) : DATA_W'(pivot);
    assign rem_sh = {rem_reg[DATA_W-1:0], num_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= mag;
            num_reg <= ONE_NUM + NUM_W'(mag >> 1);
            quo_reg <= '0;
            rem_reg <= '0;
            neg_reg <= pivot[DATA_W-1];
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? (rem_sh - {1'b0, div_reg}) : rem_sh;
        end
    end

    always_comb
    begin
        done  = done_reg;
        ovf   = 1'b0;
        recip = DATA_W'(quo_reg);
        if (neg_reg)
        begin
            if (quo_reg > NEG_MAX)
            begin
                ovf   = 1'b1;
                recip = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                recip = DATA_W'(-quo_reg);
            end
        end
        else if (quo_reg > POS_MAX)
        begin
            ovf   = 1'b1;
            recip = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gjs_dp.sv
// ----------------------------------------------------------------------------
// gjs_dp
// Solver datapath: stores, working matrix, multiplier, rounding, result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module gjs_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_acc,
    input  wire gjs_pkg::gjs_item_t   item,
    input  wire gjs_pkg::gjs_cmd_t    cmd,
    output gjs_pkg::gjs_sts_t         sts,
    output logic                      result_valid,
    output gjs_pkg::gjs_result_t      result
);
    import gjs_pkg::*;

    localparam int MAT_D = MAX_ORDER * MAX_ORDER;
    localparam int WK_AW = IDX_W + N_W;
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    logic signed [DATA_W-1:0] mat_mem [MAT_D];
    logic signed [DATA_W-1:0] rhs_mem [MAX_ORDER];
    logic signed [DATA_W-1:0] wk_mem  [2**WK_AW];

    logic signed [DATA_W-1:0] mat_rd_reg, rhs_rd_reg, rda_reg, rdb_reg;
    logic signed [DATA_W-1:0] recip_reg, coef_reg, rnd_reg;
    logic signed [63:0]       prod_reg;
    logic                     ovf_reg, rnd_ovf;
    logic                     valid_reg;
    gjs_result_t              res_reg;

    logic                     div_done, div_ovf;
    logic signed [DATA_W-1:0] div_recip;
    logic [63:0]              pmag, pm;
    logic signed [DATA_W-1:0] rnd_next;
    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] sub_val, wr_val;
    logic                     sub_ovf;

    gjs_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .pivot (rda_reg),
        .done  (div_done),
        .recip (div_recip),
        .ovf   (div_ovf)
    );

    // store writes and copy reads
    always_ff @(posedge clk)
    begin
        if (in_acc && item.action == ACT_WR_MATRIX)
            mat_mem[{item.row, item.col}] <= item.entry_value;
        if (in_acc && item.action == ACT_WR_RHS)
            rhs_mem[item.row] <= item.entry_value;
        mat_rd_reg <= mat_mem[{cmd.a_row, cmd.a_col[IDX_W-1:0]}];
        rhs_rd_reg <= rhs_mem[cmd.a_row];
    end

    // working matrix, right-hand side kept as column n
    always_ff @(posedge clk)
    begin
        if (cmd.cp_wr || cmd.wr_en)
            wk_mem[{cmd.a_row, cmd.a_col}] <= wr_val;
        rda_reg <= wk_mem[{cmd.a_row, cmd.a_col}];
        rdb_reg <= wk_mem[{cmd.b_row, cmd.a_col}];
    end

    always_comb
    begin
        pmag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        pm   = (pmag + HALF) >> FRAC_BITS;
        rnd_ovf = 1'b0;
        if (prod_reg[63])
        begin
            if (pm > 64'h8000_0000)
            begin
                rnd_ovf  = 1'b1;
                rnd_next = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                rnd_next = DATA_W'(-pm);
            end
        end
        else if (pm > 64'h7FFF_FFFF)
        begin
            rnd_ovf  = 1'b1;
            rnd_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else
        begin
            rnd_next = DATA_W'(pm);
        end
    end

    always_comb
    begin
        diff    = (DATA_W+1)'(rda_reg) - (DATA_W+1)'(rnd_reg);
        sub_ovf = diff[DATA_W] != diff[DATA_W-1];
        if (!sub_ovf)
            sub_val = diff[DATA_W-1:0];
        else if (diff[DATA_W])
            sub_val = {1'b1, {(DATA_W-1){1'b0}}};
        else
            sub_val = {1'b0, {(DATA_W-1){1'b1}}};
        if (cmd.cp_wr)
            wr_val = cmd.cp_rhs ? rhs_rd_reg : mat_rd_reg;
        else if (cmd.wr_sub)
            wr_val = sub_val;
        else
            wr_val = rnd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
            recip_reg <= div_recip;
        if (cmd.ld_coef)
            coef_reg <= rda_reg;
        if (cmd.mul_en)
            prod_reg <= cmd.mul_scale ? 64'(rda_reg) * 64'(recip_reg)
                                      : 64'(coef_reg) * 64'(rdb_reg);
        if (cmd.rnd_en)
            rnd_reg <= rnd_next;
        if (cmd.emit)
        begin
            res_reg.solution_index <= cmd.emit_err ? '0 : cmd.a_row;
            res_reg.solution_value <= cmd.emit_err ? '0 : rda_reg;
            res_reg.last           <= cmd.last;
            res_reg.status         <= cmd.emit_err ? ST_ZERO_PIVOT
                                    : (ovf_reg ? ST_OVERFLOW : ST_OK);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.emit;
            if (cmd.clr_ovf)
                ovf_reg <= 1'b0;
            else if ((div_done && div_ovf) || (cmd.rnd_en && rnd_ovf)
                     || (cmd.wr_en && cmd.wr_sub && sub_ovf))
                ovf_reg <= 1'b1;
        end
    end

    assign sts.piv_zero = rda_reg == '0;
    assign sts.div_done = div_done;
    assign result_valid = valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

FILE: rtl/gjs_ctrl.sv
// ----------------------------------------------------------------------------
// gjs_ctrl
// Solver sequencer: copy, pivot, scale, eliminate, and emit loops.
// ----------------------------------------------------------------------------
`default_nettype none

module gjs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  solve_go,
    input  wire logic [gjs_pkg::N_W-1:0] n,
    input  wire gjs_pkg::gjs_sts_t     sts,
    output gjs_pkg::gjs_cmd_t          cmd,
    output logic                       busy
);
    import gjs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CP_RD, S_CP_WR, S_PV_RD, S_PV_CHK, S_DIV,
        S_SC_RD, S_SC_MUL, S_SC_RND, S_SC_WR,
        S_EL_SEL, S_EL_CRD, S_EL_CLD, S_EL_RD, S_EL_MUL, S_EL_RND, S_EL_WR,
        S_OUT_RD, S_OUT_EMIT, S_ERR
    } state_t;

    state_t           state_reg;
    logic [IDX_W-1:0] fd_reg, i_reg;
    logic [N_W-1:0]   k_reg;
    logic [N_W-1:0]   n_m1;
    logic             i_end, fd_end, k_end;

    assign n_m1   = n - N_W'(1);
    assign i_end  = {1'b0, i_reg} == n_m1;
    assign fd_end = {1'b0, fd_reg} == n_m1;
    assign k_end  = k_reg == n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fd_reg    <= '0;
            i_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (solve_go)
                    begin
                        i_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_CP_RD;
                    end
                end
                S_CP_RD:  state_reg <= S_CP_WR;
                S_CP_WR:
                begin
                    if (k_end)
                    begin
                        k_reg <= '0;
                        if (i_end)
                        begin
                            fd_reg    <= '0;
                            state_reg <= S_PV_RD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_CP_RD;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg + N_W'(1);
                        state_reg <= S_CP_RD;
                    end
                end
                S_PV_RD:  state_reg <= S_PV_CHK;
                S_PV_CHK: state_reg <= sts.piv_zero ? S_ERR : S_DIV;
                S_DIV:
                begin
                    if (sts.div_done)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_RD:  state_reg <= S_SC_MUL;
                S_SC_MUL: state_reg <= S_SC_RND;
                S_SC_RND: state_reg <= S_SC_WR;
                S_SC_WR:
                begin
                    if (k_end)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_EL_SEL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + N_W'(1);
                        state_reg <= S_SC_RD;
                    end
                end
                S_EL_SEL:
                begin
                    if (i_reg != fd_reg)
                        state_reg <= S_EL_CRD;
                    else if (!i_end)
                        i_reg <= i_reg + IDX_W'(1);
                    else if (fd_end)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        fd_reg    <= fd_reg + IDX_W'(1);
                        state_reg <= S_PV_RD;
                    end
                end
                S_EL_CRD: state_reg <= S_EL_CLD;
                S_EL_CLD:
                begin
                    k_reg     <= '0;
                    state_reg <= S_EL_RD;
                end
                S_EL_RD:  state_reg <= S_EL_MUL;
                S_EL_MUL: state_reg <= S_EL_RND;
                S_EL_RND: state_reg <= S_EL_WR;
                S_EL_WR:
                begin
                    if (!k_end)
                    begin
                        k_reg     <= k_reg + N_W'(1);
                        state_reg <= S_EL_RD;
                    end
                    else if (!i_end)
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_EL_SEL;
                    end
                    else if (fd_end)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_OUT_RD;
                    end
                    else
                    begin
                        fd_reg    <= fd_reg + IDX_W'(1);
                        state_reg <= S_PV_RD;
                    end
                end
                S_OUT_RD: state_reg <= S_OUT_EMIT;
                S_OUT_EMIT:
                begin
                    if (i_end)
                        state_reg <= S_IDLE;
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_OUT_RD;
                    end
                end
                S_ERR:    state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd       = '0;
        cmd.a_row = i_reg;
        cmd.a_col = k_reg;
        cmd.b_row = fd_reg;
        case (state_reg)
            S_IDLE:   cmd.clr_ovf = 1'b1;
            S_CP_WR:
            begin
                cmd.cp_wr  = 1'b1;
                cmd.cp_rhs = k_end;
            end
            S_PV_RD, S_PV_CHK:
            begin
                cmd.a_row     = fd_reg;
                cmd.a_col     = {1'b0, fd_reg};
                cmd.div_start = (state_reg == S_PV_CHK) && !sts.piv_zero;
            end
            S_SC_RD, S_SC_RND: cmd.a_row = fd_reg;
            S_SC_MUL:
            begin
                cmd.a_row     = fd_reg;
                cmd.mul_en    = 1'b1;
                cmd.mul_scale = 1'b1;
            end
            S_SC_WR:
            begin
                cmd.a_row  = fd_reg;
                cmd.wr_en  = 1'b1;
            end
            S_EL_CRD, S_EL_CLD:
            begin
                cmd.a_col   = {1'b0, fd_reg};
                cmd.ld_coef = state_reg == S_EL_CLD;
            end
            S_EL_MUL: cmd.mul_en = 1'b1;
            S_EL_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sub = 1'b1;
            end
            S_OUT_RD: cmd.a_col = n;
            S_OUT_EMIT:
            begin
                cmd.a_col = n;
                cmd.emit  = 1'b1;
                cmd.last  = i_end;
            end
            S_ERR:
            begin
                cmd.emit     = 1'b1;
                cmd.emit_err = 1'b1;
                cmd.last     = 1'b1;
            end
            default: ;
        endcase
        // rounding stage of either loop
        if (state_reg == S_SC_RND || state_reg == S_EL_RND)
            cmd.rnd_en = 1'b1;
    end

    assign busy = state_reg != S_IDLE;

endmodule

`default_nettype wire

FILE: rtl/gauss_jordan_solver.sv
// Sequence: load beats are accepted while idle; a solve copies the stores into the working
// matrix, then per pivot checks it, runs the reciprocal divider (one quotient bit a cycle),
// scales the pivot row and eliminates the other rows, then emits one solution beat per row.
// Throughput: one load beat per cycle while not busy; busy stays high for the whole solve.
// Results are single-cycle strobes; the receiver cannot stall.
// Reset clears control state and sets size_reg to 16; store contents are undefined.
// ----------------------------------------------------------------------------
// gauss_jordan_solver
// Fixed-point Gauss-Jordan solver without pivoting, Q16.16 entries.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gauss_jordan_solver_macros.svh"

module gauss_jordan_solver (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire gjs_pkg::gjs_item_t    item,
    input  wire logic                  cfg_we,
    input  wire logic [gjs_pkg::N_W-1:0] cfg_wdata,
    output logic                       result_valid,
    output gjs_pkg::gjs_result_t       result
);
    import gjs_pkg::*;

    logic [N_W-1:0] size_reg;
    logic [N_W-1:0] n_eff;
    logic           in_acc;
    gjs_cmd_t       cmd;
    gjs_sts_t       sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= N_W'(MAX_ORDER);
        else if (cfg_we)
            size_reg <= cfg_wdata;
    end

    // clamp order into 1..MAX_ORDER
    always_comb
    begin
        if (size_reg == '0)
            n_eff = N_W'(1);
        else if (size_reg > N_W'(MAX_ORDER))
            n_eff = N_W'(MAX_ORDER);
        else
            n_eff = size_reg;
    end

    assign in_acc = start && !busy;

    gjs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .solve_go (in_acc && item.action == ACT_SOLVE),
        .n        (n_eff),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    gjs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_acc       (in_acc),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

    `GJS_ASSERT_NEXT(a_solve_busy, in_acc && item.action == ACT_SOLVE, busy)
    `GJS_ASSERT_NOW(a_mid_beat_busy, result_valid && !result.last, busy)
    `GJS_ASSERT_NOW(a_err_last, result_valid && result.status == ST_ZERO_PIVOT, result.last)
    `GJS_ASSERT_NEXT(a_beat_gap, result_valid, !result_valid)

endmodule

`default_nettype wire

FILE: tb/gjs_checker.sv
// ----------------------------------------------------------------------------
// gjs_checker
// Watches the load, configuration and result channels of the solver, keeps a
// shadow copy of its stores, predicts every solution beat and compares.
// ----------------------------------------------------------------------------
module gjs_checker (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  gjs_pkg::gjs_item_t       item,
    input  logic                     cfg_we,
    input  logic [gjs_pkg::N_W-1:0]  cfg_wdata,
    input  logic                     result_valid,
    input  gjs_pkg::gjs_result_t     result,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gjs_pkg::*;

    logic signed [DATA_W-1:0] a_shadow [MAX_ORDER][MAX_ORDER];
    logic signed [DATA_W-1:0] b_shadow [MAX_ORDER];
    logic [N_W-1:0]           order_reg;
    bit                       sat_hit;
    gjs_result_t              solution_q [$];

    function automatic logic signed [31:0] clamp_sum(longint v);
        if (v > 64'sd2147483647) begin sat_hit = 1; return 32'sh7fffffff; end
        if (v < -64'sd2147483648) begin sat_hit = 1; return 32'sh80000000; end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] apply_sign(longint mag, bit neg);
        if (neg) begin
            if (mag > 64'sh80000000) begin sat_hit = 1; return 32'sh80000000; end
            return 32'(-mag);
        end
        if (mag > 64'sh7fffffff) begin sat_hit = 1; return 32'sh7fffffff; end
        return mag[31:0];
    endfunction

    function automatic logic signed [31:0] q_mul(logic signed [31:0] x,
                                                 logic signed [31:0] y);
        longint p, m;
        p = longint'(x) * longint'(y);
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        return apply_sign(m, p < 0);
    endfunction

    function automatic logic signed [31:0] q_recip(logic signed [31:0] x);
        longint m, q;
        m = (x < 0) ? -longint'(x) : longint'(x);
        q = ((64'sd1 << (2 * FRAC_BITS)) + m / 2) / m;
        return apply_sign(q, x < 0);
    endfunction

    task automatic predict_solution();
        logic signed [31:0] wa [MAX_ORDER][MAX_ORDER];
        logic signed [31:0] wb [MAX_ORDER];
        logic signed [31:0] r, c;
        gjs_result_t        res;
        int                 n;
        n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
        sat_hit = 0;
        wa = a_shadow;
        wb = b_shadow;
        for (int p = 0; p < n; p++) begin
            if (wa[p][p] == 0) begin
                res = '{solution_index: '0, solution_value: '0, last: 1'b1,
                        status: ST_ZERO_PIVOT};
                solution_q.push_back(res);
                return;
            end
            r = q_recip(wa[p][p]);
            for (int k = 0; k < n; k++) wa[p][k] = q_mul(wa[p][k], r);
            wb[p] = q_mul(wb[p], r);
            for (int i = 0; i < n; i++) begin
                if (i == p) continue;
                c = wa[i][p];
                for (int k = 0; k < n; k++)
                    wa[i][k] = clamp_sum(longint'(wa[i][k]) - longint'(q_mul(c, wa[p][k])));
                wb[i] = clamp_sum(longint'(wb[i]) - longint'(q_mul(c, wb[p])));
            end
        end
        for (int i = 0; i < n; i++) begin
            res.solution_index = IDX_W'(i);
            res.solution_value = wb[i];
            res.last           = (i == n - 1);
            res.status         = sat_hit ? ST_OVERFLOW : ST_OK;
            solution_q.push_back(res);
        end
    endtask

    initial begin
        errors    = 0;
        pending   = 0;
        order_reg = 5'd16;
        foreach (a_shadow[i, j]) a_shadow[i][j] = '0;
        foreach (b_shadow[i]) b_shadow[i] = '0;
    end

    always @(posedge clk) begin
        gjs_result_t want;
        if (rst_n) begin
            if (result_valid) begin
                if (solution_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected solution beat %p", result);
                end else begin
                    want = solution_q.pop_front();
                    if (result.solution_index !== want.solution_index ||
                        result.solution_value !== want.solution_value ||
                        result.last !== want.last || result.status !== want.status) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: solution beat mismatch: expected %p, got %p",
                                     want, result);
                    end
                end
            end
            if (cfg_we)
                order_reg = cfg_wdata;
            if (start && !busy) begin
                case (gjs_action_t'(item.action))
                    ACT_WR_MATRIX: a_shadow[item.row][item.col] = item.entry_value;
                    ACT_WR_RHS:    b_shadow[item.row] = item.entry_value;
                    ACT_SOLVE:     predict_solution();
                    default: ;
                endcase
            end
            pending = solution_q.size();
        end
    end
endmodule

FILE: tb/tb_gauss_jordan_solver.sv
// ----------------------------------------------------------------------------
// tb_gauss_jordan_solver
// Loads random systems of several orders, solves them and lets the checker
// compare every solution beat, including zero pivot and saturation cases.
// ----------------------------------------------------------------------------
module tb_gauss_jordan_solver;
    timeunit 1ns;
    timeprecision 1ps;
    import gjs_pkg::*;

    localparam int SYS_WELL  = 0;
    localparam int SYS_ZERO  = 1;
    localparam int SYS_HUGE  = 2;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                start = 0;
    logic                busy;
    gjs_item_t           item = '0;
    logic                cfg_we = 0;
    logic [N_W-1:0]      cfg_wdata = '0;
    logic                result_valid;
    gjs_result_t         result;
    int                  errors, pending;
    int                  beats_sent = 0, solves_sent = 0;
    bit                  no_gaps = 0;

    always #6 clk = ~clk;

    gauss_jordan_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    gjs_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result),
        .errors(errors), .pending(pending)
    );

    task automatic send_beat(gjs_action_t act, int r, int c, logic [31:0] v);
        @(negedge clk);
        if (!no_gaps && $urandom_range(99) < 13) begin
            start <= 0;
            repeat ($urandom_range(3)) @(negedge clk);
            @(negedge clk);
        end
        start <= 1;
        item  <= '{action: act, row: IDX_W'(r), col: IDX_W'(c), entry_value: v};
        do @(posedge clk); while (busy);
        beats_sent++;
        if (act == ACT_SOLVE) solves_sent++;
    endtask

    // wait out the current solve, then write the order register
    task automatic set_order(logic [N_W-1:0] v);
        @(negedge clk);
        start <= 0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_value(int kind, bit diag);
        if (kind == SYS_HUGE) return $urandom;
        if (diag)
            return ($urandom_range(1) ? 32'd1 : -32'sd1) *
                   int'($urandom_range(4 << 16, 8 << 16));
        return int'($urandom_range(2 << 16)) - (1 << 16);
    endfunction

    task automatic run_system(logic [N_W-1:0] cfg, int kind);
        int n, zr;
        n  = (cfg == 0) ? 1 : (cfg > MAX_ORDER ? MAX_ORDER : cfg);
        zr = $urandom_range(n - 1);
        set_order(cfg);
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++)
                send_beat(ACT_WR_MATRIX, r, c,
                          (kind == SYS_ZERO && r == zr && c == zr) ? 32'd0
                                                                   : pick_value(kind, r == c));
            send_beat(ACT_WR_RHS, r, $urandom_range(15),
                      kind == SYS_HUGE ? $urandom : int'($urandom_range(16 << 16)) - (8 << 16));
            // drop in an ignored beat now and then
            if ($urandom_range(9) == 0)
                send_beat(ACT_NONE, $urandom_range(15), $urandom_range(15), $urandom);
        end
        send_beat(ACT_SOLVE, $urandom_range(15), $urandom_range(15), $urandom);
    endtask

    initial begin
        int dice;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        // directed: smallest orders, ignored beat, zero pivot, saturation
        run_system(5'd1, SYS_WELL);
        send_beat(ACT_NONE, 15, 15, 32'hffffffff);
        run_system(5'd0, SYS_WELL);
        send_beat(ACT_WR_MATRIX, 0, 0, 32'h80000000);
        send_beat(ACT_WR_RHS, 0, 0, 32'h7fffffff);
        send_beat(ACT_SOLVE, 0, 0, 32'd0);
        run_system(5'd2, SYS_ZERO);
        run_system(5'd2, SYS_HUGE);
        // random phases, one long stretch without gaps
        while (beats_sent < 165) begin
            no_gaps = (solves_sent >= 10 && solves_sent < 16);
            dice = $urandom_range(99);
            run_system(N_W'($urandom_range(2, 4)),
                       dice < 75 ? SYS_WELL : (dice < 88 ? SYS_ZERO : SYS_HUGE));
        end
        no_gaps = 0;
        // one larger order to finish
        run_system(5'd6, SYS_WELL);
        @(negedge clk);
        start <= 0;
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Covered %0d load/solve beats in %0d solves, orders 1 to 6.",
                 beats_sent, solves_sent);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d solution beats outstanding", pending);
        $display("Test completed with failures");
        $finish;
    end
endmodule
